// ===== hw/rtl/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared constants, codes and controller/datapath interface types for the
// fuzzy cluster distance block.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int MAX_OBJECTS_DEF  = 64;
  localparam int MAX_CLUSTERS_DEF = 8;

  localparam int REQ_W      = 2;
  localparam int ROW_W      = 6;
  localparam int VAL_W      = 32;
  localparam int MEMB_W     = 17;
  localparam int MEMB_ONE   = 65536;
  localparam int CLU_W      = 3;
  localparam int CLU_N      = 1 << CLU_W;
  localparam int CCNT_W     = 4;
  localparam int OCNT_W     = 7;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIV_NUM_W  = 128;
  localparam int DIV_W      = 64;

  localparam logic [REQ_W-1:0] REQ_LOAD_DIST = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_MEMB = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEG_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_NA       = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ADD_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd2;

  localparam logic              ADD_MODE_RST      = 1'b1;
  localparam logic [OCNT_W-1:0] OBJECT_COUNT_RST  = 7'd64;
  localparam logic [CCNT_W-1:0] CLUSTER_COUNT_RST = 4'd8;

  typedef struct packed {
    logic             accept;
    logic             clr_all;
    logic             pass_start;
    logic             var_mode;
    logic [CLU_W-1:0] ca;
    logic [CLU_W-1:0] cb;
    logic             card_wr;
    logic             var_wr;
    logic             ld_a;
    logic             ld_b;
    logic             div_start;
    logic             sqrt_start;
    logic             emit;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic acc_zero;
    logic pair_empty;
    logic div_done;
    logic mean_ge;
    logic sqrt_done;
  } stat_t;

endpackage

// ===== hw/rtl/fcd_ram.sv =====
// ----------------------------------------------------------------------------
// fcd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/fcd_div.sv =====
// ----------------------------------------------------------------------------
// fcd_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit per
// cycle, saturates when the quotient would not fit in 64 bits.
// ----------------------------------------------------------------------------
module fcd_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fcd_pkg::DIV_NUM_W-1:0]  num,
  input  logic [fcd_pkg::DIV_W-1:0]      den,
  output logic [fcd_pkg::DIV_W-1:0]      quot,
  output logic                           done
);
  import fcd_pkg::*;

  logic [DIV_W-1:0]         rem_r, nq_r, den_r;
  logic [$clog2(DIV_W)-1:0] cnt_r;
  logic                     run_r;
  logic [DIV_W:0]           shifted, sub;
  logic                     fit;

  assign shifted = {rem_r, nq_r[DIV_W-1]};
  assign sub     = shifted - {1'b0, den_r};
  assign fit     = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= num[DIV_NUM_W-1:DIV_W] < den;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == '1) begin
        run_r <= 1'b0;
      end
    end
  end

  // dividend low half shifts out of nq_r while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= num[DIV_NUM_W-1:DIV_W];
      nq_r  <= (num[DIV_NUM_W-1:DIV_W] >= den) ? '1 : num[DIV_W-1:0];
    end else if (run_r) begin
      rem_r <= fit ? sub[DIV_W-1:0] : shifted[DIV_W-1:0];
      nq_r  <= {nq_r[DIV_W-2:0], fit};
    end
  end

  assign quot = nq_r;
  assign done = !run_r;

endmodule

// ===== hw/rtl/fcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcd_ctrl
// Controller: walks the variance passes per cluster, then the cluster pairs,
// sequencing cross sums, divisions, square roots and result strobes.
// ----------------------------------------------------------------------------
module fcd_ctrl #(
  parameter int MAX_CLUSTERS = fcd_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fcd_pkg::REQ_W-1:0]   in_req_type,
  input  logic [fcd_pkg::CCNT_W-1:0]  cluster_count,
  input  fcd_pkg::stat_t              st,
  output fcd_pkg::cmd_t               cmd,
  output logic                        busy
);
  import fcd_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_VPASS = 15'b000000000000010,
    S_VRUN  = 15'b000000000000100,
    S_VSQ   = 15'b000000000001000,
    S_VDS   = 15'b000000000010000,
    S_VDIV  = 15'b000000000100000,
    S_PLDA  = 15'b000000001000000,
    S_PLDB  = 15'b000000010000000,
    S_PCHK  = 15'b000000100000000,
    S_PRUN  = 15'b000001000000000,
    S_PDS   = 15'b000010000000000,
    S_PDIV  = 15'b000100000000000,
    S_PCMP  = 15'b001000000000000,
    S_PSQRT = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CLU_W-1:0]   ca_r, ca_nxt, cb_r, cb_nxt;
  logic               var_r, var_nxt;
  logic [CCNT_W-1:0]  k;
  logic               last_clu, last_pair;

  assign k = (int'(cluster_count) > MAX_CLUSTERS) ? CCNT_W'(MAX_CLUSTERS) : cluster_count;
  assign last_clu  = ({1'b0, ca_r} == k - 1'b1);
  assign last_pair = last_clu && (cb_r == ca_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    var_nxt        = var_r;
    cmd            = '0;
    cmd.ca         = ca_r;
    cmd.cb         = cb_r;
    cmd.var_mode   = var_r;
    cmd.accept     = start && (state_r == S_IDLE);
    busy           = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && in_req_type == REQ_COMPUTE) begin
          cmd.clr_all = 1'b1;
          if (k >= CCNT_W'(2)) begin
            ca_nxt    = '0;
            cb_nxt    = '0;
            var_nxt   = 1'b1;
            state_nxt = S_VPASS;
          end
        end
      end
      S_VPASS: begin
        cmd.pass_start = 1'b1;
        state_nxt      = S_VRUN;
      end
      S_VRUN: begin
        if (st.pass_done) begin
          state_nxt = S_VSQ;
        end
      end
      S_VSQ: begin
        cmd.card_wr = 1'b1;
        state_nxt   = S_VDS;
      end
      S_VDS, S_VDIV: begin
        if (state_r == S_VDS && !st.acc_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_VDIV;
        end else if (state_r == S_VDS || st.div_done) begin
          cmd.var_wr = 1'b1;
          if (last_clu) begin
            ca_nxt    = CLU_W'(1);
            cb_nxt    = '0;
            var_nxt   = 1'b0;
            state_nxt = S_PLDA;
          end else begin
            ca_nxt    = ca_r + 1'b1;
            cb_nxt    = ca_r + 1'b1;
            state_nxt = S_VPASS;
          end
        end
      end
      S_PLDA: begin
        cmd.ld_a  = 1'b1;
        state_nxt = S_PLDB;
      end
      S_PLDB: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (st.pair_empty) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_PRUN;
        end
      end
      S_PRUN: begin
        if (st.pass_done) begin
          state_nxt = S_PDS;
        end
      end
      S_PDS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_PDIV;
      end
      S_PDIV: begin
        if (st.div_done) begin
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (st.mean_ge) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_PSQRT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_PSQRT: begin
        if (st.sqrt_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = last_pair;
        if (last_pair) begin
          state_nxt = S_IDLE;
        end else begin
          if (cb_r == ca_r - 1'b1) begin
            ca_nxt = ca_r + 1'b1;
            cb_nxt = '0;
          end else begin
            cb_nxt = cb_r + 1'b1;
          end
          state_nxt = S_PLDA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ca_r    <= '0;
      cb_r    <= '0;
      var_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ca_r    <= ca_nxt;
      cb_r    <= cb_nxt;
      var_r   <= var_nxt;
    end
  end

endmodule

// ===== hw/rtl/fcd_dp.sv =====
// ----------------------------------------------------------------------------
// fcd_dp
// Datapath: distance and membership stores, cross-sum pipeline, cardinality
// and variance registers, divider, square root unit and result registers.
// ----------------------------------------------------------------------------
module fcd_dp #(
  parameter int MAX_OBJECTS  = fcd_pkg::MAX_OBJECTS_DEF,
  parameter int MAX_CLUSTERS = fcd_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fcd_pkg::cmd_t               cmd,
  output fcd_pkg::stat_t              st,
  input  logic [fcd_pkg::REQ_W-1:0]   in_req_type,
  input  logic [fcd_pkg::ROW_W-1:0]   in_row_index,
  input  logic [fcd_pkg::ROW_W-1:0]   in_col_index,
  input  logic [fcd_pkg::VAL_W-1:0]   in_value,
  input  logic                        add_mode,
  input  logic [fcd_pkg::OCNT_W-1:0]  object_count,
  output logic                        out_valid,
  output logic [fcd_pkg::CLU_W-1:0]   out_cluster_a,
  output logic [fcd_pkg::CLU_W-1:0]   out_cluster_b,
  output logic [fcd_pkg::VAL_W-1:0]   out_distance,
  output logic [fcd_pkg::STAT_W-1:0]  out_status,
  output logic                        out_last
);
  import fcd_pkg::*;

  localparam int OIW     = $clog2(MAX_OBJECTS);
  localparam int NW      = $clog2(MAX_OBJECTS + 1);
  localparam int DEPTH_D = MAX_OBJECTS * MAX_OBJECTS;
  localparam int DAW     = $clog2(DEPTH_D);
  localparam int DEPTH_M = MAX_OBJECTS * MAX_CLUSTERS;
  localparam int MAW     = $clog2(DEPTH_M);
  localparam int CARD_W  = MEMB_W + OIW;
  localparam int PROD_W  = 2 * CARD_W;
  localparam int W_W     = 2 * MEMB_W;
  localparam int D2_W    = 2 * VAL_W;
  localparam int PL_W    = W_W + VAL_W;
  localparam int TERM_W  = W_W + D2_W;
  localparam int ACC_W   = TERM_W + 2 * OIW;

  // loads
  logic              dist_we, memb_we;
  logic [DAW-1:0]    dist_waddr, dist_raddr;
  logic [MAW-1:0]    memb_waddr, memb_raddr_a, memb_raddr_b;
  logic [MEMB_W-1:0] memb_wdata, ua, ub;
  logic [VAL_W-1:0]  dd;

  assign dist_we = cmd.accept && in_req_type == REQ_LOAD_DIST
                   && int'(in_row_index) < MAX_OBJECTS && int'(in_col_index) < MAX_OBJECTS;
  assign memb_we = cmd.accept && in_req_type == REQ_LOAD_MEMB
                   && int'(in_row_index) < MAX_OBJECTS && int'(in_col_index) < MAX_CLUSTERS;
  assign dist_waddr = DAW'(int'(in_row_index) * MAX_OBJECTS + int'(in_col_index));
  assign memb_waddr = MAW'(int'(in_row_index) * MAX_CLUSTERS + int'(in_col_index));
  assign memb_wdata = (in_value > VAL_W'(MEMB_ONE)) ? MEMB_W'(MEMB_ONE)
                                                      : in_value[MEMB_W-1:0];

  // pass sequencer over all object pairs (i, j)
  logic [OIW-1:0] i_r, j_r;
  logic           iss_r;
  logic [NW-1:0]  n_eff;
  logic           row_end, iss_last;

  assign n_eff = (int'(object_count) > MAX_OBJECTS) ? NW'(MAX_OBJECTS) : NW'(object_count);
  assign row_end  = (NW'(j_r) == n_eff - 1'b1);
  assign iss_last = row_end && (NW'(i_r) == n_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
      i_r   <= '0;
      j_r   <= '0;
    end else if (cmd.pass_start) begin
      iss_r <= (n_eff != '0);
      i_r   <= '0;
      j_r   <= '0;
    end else if (iss_r) begin
      if (iss_last) begin
        iss_r <= 1'b0;
      end
      j_r <= row_end ? '0 : j_r + 1'b1;
      i_r <= row_end ? i_r + 1'b1 : i_r;
    end
  end

  assign memb_raddr_a = MAW'(int'(i_r) * MAX_CLUSTERS + int'(cmd.ca));
  assign memb_raddr_b = MAW'(int'(j_r) * MAX_CLUSTERS + int'(cmd.cb));
  assign dist_raddr   = DAW'(int'(i_r) * MAX_OBJECTS + int'(j_r));

  fcd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH_D)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(in_value),
    .raddr(dist_raddr), .rdata(dd)
  );

  // membership is kept twice so that row and column weights read together
  fcd_ram #(.WIDTH(MEMB_W), .DEPTH(DEPTH_M)) u_memb_a (
    .clk(clk), .we(memb_we), .waddr(memb_waddr), .wdata(memb_wdata),
    .raddr(memb_raddr_a), .rdata(ua)
  );

  fcd_ram #(.WIDTH(MEMB_W), .DEPTH(DEPTH_M)) u_memb_b (
    .clk(clk), .we(memb_we), .waddr(memb_waddr), .wdata(memb_wdata),
    .raddr(memb_raddr_b), .rdata(ub)
  );

  // cross-sum pipeline
  logic              s1_v_r, s1_first_r, s2_v_r, s3_v_r, s4_v_r;
  logic [W_W-1:0]    w_r;
  logic [D2_W-1:0]   d2_r;
  logic [PL_W-1:0]   plo_r, phi_r;
  logic [TERM_W-1:0] term_r;
  logic [ACC_W-1:0]  acc_r;
  logic [CARD_W-1:0] card_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_first_r <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
    end else begin
      s1_v_r     <= iss_r;
      s1_first_r <= iss_r && (j_r == '0);
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s2_v_r;
      s4_v_r     <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= W_W'(ua) * W_W'(ub);
    d2_r   <= D2_W'(dd) * D2_W'(dd);
    plo_r  <= PL_W'(w_r) * PL_W'(d2_r[VAL_W-1:0]);
    phi_r  <= PL_W'(w_r) * PL_W'(d2_r[D2_W-1:VAL_W]);
    term_r <= TERM_W'(plo_r) + {phi_r, {VAL_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      acc_r      <= '0;
      card_acc_r <= '0;
    end else begin
      if (s4_v_r) begin
        acc_r <= acc_r + ACC_W'(term_r);
      end
      // cardinality takes each row weight once, on the first column
      if (s1_v_r && s1_first_r && cmd.var_mode) begin
        card_acc_r <= card_acc_r + CARD_W'(ua);
      end
    end
  end

  // per-cluster cardinality and variance
  logic [CARD_W-1:0] card_r [CLU_N];
  logic [DIV_W-1:0]  var_r  [CLU_N];
  logic [CARD_W-1:0] c1_r, c2_r;
  logic [DIV_W-1:0]  v1_r, v2_r;
  logic [CLU_W-1:0]  rd_idx;
  logic [PROD_W-1:0] prod_r;
  logic [DIV_W-1:0]  den, quot, vsum, diff;
  logic              div_done, empty, ge;

  assign rd_idx = cmd.ld_b ? cmd.cb : cmd.ca;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      for (int c = 0; c < CLU_N; c++) begin
        card_r[c] <= '0;
        var_r[c]  <= '0;
      end
    end else begin
      if (cmd.card_wr) begin
        card_r[cmd.ca] <= card_acc_r;
      end
      if (cmd.var_wr) begin
        var_r[cmd.ca] <= (card_acc_r == '0) ? '0 : quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      c1_r <= card_r[rd_idx];
      v1_r <= var_r[rd_idx];
    end
    if (cmd.ld_b) begin
      c2_r <= card_r[rd_idx];
      v2_r <= var_r[rd_idx];
    end
    prod_r <= cmd.var_mode ? PROD_W'(card_acc_r) * PROD_W'(card_acc_r)
                           : PROD_W'(c1_r) * PROD_W'(c2_r);
  end

  assign den = cmd.var_mode ? DIV_W'({prod_r, 1'b0}) : DIV_W'(prod_r);

  fcd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(DIV_NUM_W'(acc_r)), .den(den), .quot(quot), .done(div_done)
  );

  assign vsum  = v1_r + v2_r;
  assign ge    = quot >= vsum;
  assign diff  = quot - vsum;
  assign empty = (c1_r == '0) || (c2_r == '0);

  // integer square root, two bits of the radicand per cycle
  logic [DIV_W-1:0] sx_r, sres_r, sbit_r, trial;
  logic             srun_r;

  assign trial = sres_r + sbit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srun_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      srun_r <= 1'b1;
    end else if (srun_r && sbit_r[0]) begin
      srun_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sx_r   <= diff;
      sres_r <= '0;
      sbit_r <= DIV_W'(1) << (DIV_W - 2);
    end else if (srun_r) begin
      if (sx_r >= trial) begin
        sx_r   <= sx_r - trial;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  // result registers
  logic                out_valid_r;
  logic [CLU_W-1:0]    out_a_r, out_b_r;
  logic [VAL_W-1:0]    out_dist_r;
  logic [STAT_W-1:0]   out_stat_r;
  logic                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_a_r    <= cmd.ca;
      out_b_r    <= cmd.cb;
      out_last_r <= cmd.last;
      out_dist_r <= (empty || !ge) ? '0 : sres_r[VAL_W-1:0];
      if (empty) begin
        out_stat_r <= ST_EMPTY;
      end else if (ge) begin
        out_stat_r <= ST_OK;
      end else if (add_mode) begin
        out_stat_r <= ST_NEG_ZERO;
      end else begin
        out_stat_r <= ST_NA;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cluster_a = out_a_r;
  assign out_cluster_b = out_b_r;
  assign out_distance  = out_dist_r;
  assign out_status    = out_stat_r;
  assign out_last      = out_last_r;

  assign st.pass_done  = !(iss_r || s1_v_r || s2_v_r || s3_v_r || s4_v_r);
  assign st.acc_zero   = (card_acc_r == '0);
  assign st.pair_empty = empty;
  assign st.div_done   = div_done;
  assign st.mean_ge    = ge;
  assign st.sqrt_done  = !srun_r;

endmodule

// ===== hw/rtl/fuzzy_cluster_distance.sv =====
// ----------------------------------------------------------------------------
// fuzzy_cluster_distance
// Between-cluster distances from a loaded distance matrix and fuzzy partition.
// ----------------------------------------------------------------------------
// load transactions are taken while idle and may come back to back
// a compute transaction holds busy through the variance pass of each cluster and the
// pass of each cluster pair, paced by the one-pair-per-cycle cross-sum pipeline, the
// bit-serial divider and the square root
// one result per pair leaves on an out_valid strobe; the receiver cannot stall
// synchronous active-low reset clears control and configuration, stores stay undefined
module fuzzy_cluster_distance #(
  parameter int MAX_OBJECTS  = fcd_pkg::MAX_OBJECTS_DEF,
  parameter int MAX_CLUSTERS = fcd_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [fcd_pkg::REQ_W-1:0]       in_req_type,
  input  logic [fcd_pkg::ROW_W-1:0]       in_row_index,
  input  logic [fcd_pkg::ROW_W-1:0]       in_col_index,
  input  logic [fcd_pkg::VAL_W-1:0]       in_value,
  output logic                            out_valid,
  output logic [fcd_pkg::CLU_W-1:0]       out_cluster_a,
  output logic [fcd_pkg::CLU_W-1:0]       out_cluster_b,
  output logic [fcd_pkg::VAL_W-1:0]       out_distance,
  output logic [fcd_pkg::STAT_W-1:0]      out_status,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fcd_pkg::*;

  logic              add_mode_r;
  logic [OCNT_W-1:0] object_count_r;
  logic [CCNT_W-1:0] cluster_count_r;
  cmd_t              cmd;
  stat_t             st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_mode_r      <= ADD_MODE_RST;
      object_count_r  <= OBJECT_COUNT_RST;
      cluster_count_r <= CLUSTER_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADD_MODE:      add_mode_r      <= cfg_data[0];
        CFG_OBJECT_COUNT:  object_count_r  <= cfg_data[OCNT_W-1:0];
        CFG_CLUSTER_COUNT: cluster_count_r <= cfg_data[CCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fcd_ctrl #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req_type(in_req_type),
    .cluster_count(cluster_count_r), .st(st), .cmd(cmd), .busy(busy)
  );

  fcd_dp #(.MAX_OBJECTS(MAX_OBJECTS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_req_type(in_req_type), .in_row_index(in_row_index),
    .in_col_index(in_col_index), .in_value(in_value),
    .add_mode(add_mode_r), .object_count(object_count_r),
    .out_valid(out_valid), .out_cluster_a(out_cluster_a),
    .out_cluster_b(out_cluster_b), .out_distance(out_distance),
    .out_status(out_status), .out_last(out_last)
  );

endmodule

// ===== hw/rtl/fcd_checker.sv =====
// ----------------------------------------------------------------------------
// fcd_checker
// Port-level checks on result sequencing for the fuzzy cluster distance block.
// ----------------------------------------------------------------------------
module fcd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           busy,
  input logic                           out_valid,
  input logic [fcd_pkg::CLU_W-1:0]      out_cluster_a,
  input logic [fcd_pkg::CLU_W-1:0]      out_cluster_b,
  input logic [fcd_pkg::VAL_W-1:0]      out_distance,
  input logic [fcd_pkg::STAT_W-1:0]     out_status,
  input logic                           out_last
);
  import fcd_pkg::*;

  // results only come out of a running compute transaction
  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a running compute");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cluster_b < out_cluster_a))
    else $error("pair not ordered with k2 below k1");

  a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_distance == '0))
    else $error("nonzero distance on a flagged pair");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result after the final pair");

  // every run ends on the pair (k-1, k-2)
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_cluster_b == out_cluster_a - 1'b1))
    else $error("final pair is not adjacent");

endmodule

bind fuzzy_cluster_distance fcd_checker u_fcd_checker (.*);
